// ===== design/assert_macros.svh =====
// Assertion helpers shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define B64_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// The expression must never be true outside reset.
`define B64_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== design/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

    // Depth of the job queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ASCII anchors of the alphabet.
    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] UPPER_BASE = 7'h41;
    localparam logic [6:0] LOWER_BASE = 7'h47;
    localparam logic [6:0] DIGIT_DOWN = 7'h04;
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;
    localparam logic [6:0] SLASH_CHAR = 7'h2F;

    // Group phases.
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // One classified byte: up to four characters, the index of the last one,
    // and whether the final character closes the message.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } job_t;

    // Map a six-bit value to its Base64 character.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] wide;
        wide = {1'b0, v};
        if (v < 6'd26) begin
            return UPPER_BASE + wide;
        end else if (v < 6'd52) begin
            return LOWER_BASE + wide;
        end else if (v < 6'd62) begin
            return wide - DIGIT_DOWN;
        end else if (v == 6'd62) begin
            return PLUS_CHAR;
        end else begin
            return SLASH_CHAR;
        end
    endfunction

endpackage

// ===== design/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake          | Payload
// s_ (in)   | slave     | s_tvalid/s_tready  | s_tdata[7:0] data_byte, s_tlast final_byte
// m_ (out)  | master    | m_tvalid/m_tready  | m_tdata[6:0] char_code, m_tlast last_char
//
// The output emits one character per cycle while m_tready is high; a byte is
// classified combinationally as it is accepted, and its one to four characters
// leave in turn from the output register, four for a full group of three bytes.
// A two-entry job queue accepts input while output is stalled, until it is full.
// Reset is synchronous and active low; it clears the group phase and all control.
// No clearing pass is needed after reset.

module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic       m_tlast    // last_char
);
    import b64e_pkg::*;

    logic       push_valid, push_ready;
    job_t       push_job, head_job;
    logic       head_valid, pop;
    logic [6:0] out_char;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_fin     (s_tlast),
        .in_ready   (s_tready),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    b64e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_char   (out_char),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

// ===== design/b64e_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_fin,
    output logic           in_ready,
    output logic           push_valid,
    output b64e_pkg::job_t push_job,
    input  logic           push_ready
);
    import b64e_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic       accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // Classify the byte by its place in the group and build its characters.
    always_comb begin
        push_job   = '0;
        phase_next = phase_reg;
        left_next  = left_reg;
        push_job.fin = in_fin;
        unique case (phase_reg)
            PHASE_1: begin
                push_job.chars[0] = sextet_char({left_reg[1:0], in_byte[7:4]});
                if (in_fin) begin
                    push_job.chars[1] = sextet_char({in_byte[3:0], 2'b00});
                    push_job.chars[2] = PAD_CHAR;
                    push_job.last_idx = 2'd2;
                    phase_next = PHASE_0;
                    left_next  = 4'd0;
                end else begin
                    push_job.last_idx = 2'd0;
                    phase_next = PHASE_2;
                    left_next  = in_byte[3:0];
                end
            end
            PHASE_2: begin
                push_job.chars[0] = sextet_char({left_reg, in_byte[7:6]});
                push_job.chars[1] = sextet_char(in_byte[5:0]);
                push_job.last_idx = 2'd1;
                phase_next = PHASE_0;
                left_next  = 4'd0;
            end
            default: begin
                push_job.chars[0] = sextet_char(in_byte[7:2]);
                if (in_fin) begin
                    push_job.chars[1] = sextet_char({in_byte[1:0], 4'b0000});
                    push_job.chars[2] = PAD_CHAR;
                    push_job.chars[3] = PAD_CHAR;
                    push_job.last_idx = 2'd3;
                    phase_next = PHASE_0;
                    left_next  = 4'd0;
                end else begin
                    push_job.last_idx = 2'd0;
                    phase_next = PHASE_1;
                    left_next  = {2'b00, in_byte[1:0]};
                end
            end
        endcase
    end

    // Group state advances only on an accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_0;
            left_reg  <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // Phase three is never reached.
    `B64_NEVER(a_phase_legal, aclk, aresetn, phase_reg == 2'd3)

endmodule

// ===== design/b64e_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  b64e_pkg::job_t push_job,
    output logic           push_ready,
    output logic           head_valid,
    output b64e_pkg::job_t head_job,
    input  logic           pop
);
    import b64e_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `B64_NEVER(a_count_bound, aclk, aresetn, count_reg > QCNT_W'(QDEPTH))
    `B64_ASSERT(a_ptr_gap, aclk, aresetn,
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) || (wr_ptr_reg != rd_ptr_reg))

endmodule

// ===== design/b64e_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  b64e_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    output logic [6:0]     out_char,
    output logic           out_last,
    input  logic           out_ready
);
    import b64e_pkg::*;

    job_t       job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [6:0] ochar_reg, ochar_next;
    logic       olast_reg, olast_next;
    logic       load;

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;
    assign load      = !ovalid_reg || out_ready;

    // Serialize the current job, or start the next one from the queue head.
    always_comb begin
        job_next    = job_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        pop         = 1'b0;
        if (load) begin
            if (busy_reg) begin
                ovalid_next = 1'b1;
                ochar_next  = job_reg.chars[idx_reg];
                olast_next  = job_reg.fin && (idx_reg == job_reg.last_idx);
                if (idx_reg == job_reg.last_idx) begin
                    busy_next = 1'b0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end else if (head_valid) begin
                pop         = 1'b1;
                ovalid_next = 1'b1;
                ochar_next  = head_job.chars[0];
                olast_next  = head_job.fin && (head_job.last_idx == 2'd0);
                job_next    = head_job;
                if (head_job.last_idx != 2'd0) begin
                    busy_next = 1'b1;
                    idx_next  = 2'd1;
                end
            end else begin
                ovalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    // While a job is open its index points past the first char and not past the last.
    `B64_ASSERT(a_idx_range, aclk, aresetn,
        !busy_reg || (idx_reg != 2'd0 && idx_reg <= job_reg.last_idx))
    // No new job is taken while the current one is unfinished.
    `B64_NEVER(a_pop_idle, aclk, aresetn, pop && busy_reg)

endmodule
